[rtl/prbt_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the backoff function of the peer retry backoff table.
package prbt_pkg;

  localparam int PEER_SLOTS_DEF = 64;
  localparam int TIME_BITS_DEF  = 48;

  localparam int PEER_SLOT_W = 6;
  localparam int ATT_W       = 8;
  localparam int TOTAL_W     = 7;
  localparam int BASE_W      = 16;
  localparam int DELAY_W     = 24;
  localparam int SHIFT_W     = BASE_W + DELAY_W;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;

  localparam logic [BASE_W-1:0]  BASE_DELAY_RST    = BASE_W'(5);
  localparam logic [DELAY_W-1:0] MAX_DELAY_RST     = DELAY_W'(300);
  localparam logic [ATT_W-1:0]   ATTEMPT_LIMIT_RST = ATT_W'(8);
  localparam logic [DELAY_W-1:0] COOLDOWN_RST      = DELAY_W'(3600);

  typedef enum logic [2:0] {
    OP_CANDIDATE  = 3'd0,
    OP_DISCONNECT = 3'd1,
    OP_ATTEMPT    = 3'd2,
    OP_SUCCESS    = 3'd3,
    OP_FAILURE    = 3'd4,
    OP_QUARANTINE = 3'd5,
    OP_LIFT       = 3'd6,
    OP_QUERY      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    REG_BASE_DELAY    = 2'd0,
    REG_MAX_DELAY     = 2'd1,
    REG_ATTEMPT_LIMIT = 2'd2,
    REG_COOLDOWN      = 2'd3
  } reg_t;

  // base doubled n times, stopping at the cap once reached; n = 0 gives base uncapped
  function automatic logic [DELAY_W-1:0] prbt_backoff(
    input logic [BASE_W-1:0]  base,
    input logic [DELAY_W-1:0] cap,
    input logic [ATT_W-1:0]   n
  );
    logic [4:0]         sh;
    logic [SHIFT_W-1:0] wide;
    logic [DELAY_W-1:0] res;
    sh   = (n >= ATT_W'(DELAY_W)) ? 5'(DELAY_W) : n[4:0];
    wide = SHIFT_W'(base) << sh;
    if (n == '0) begin
      res = DELAY_W'(base);
    end else if (wide >= SHIFT_W'(cap)) begin
      res = cap;
    end else begin
      res = wide[DELAY_W-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/prbt_if.sv]
`timescale 1ns / 1ps
// Request and result channel interfaces of the peer retry backoff table.
interface prbt_req_if #(
  parameter int TIME_BITS = prbt_pkg::TIME_BITS_DEF
);
  import prbt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [2:0]             opcode;
  logic [PEER_SLOT_W-1:0] peer_slot;
  logic [TIME_BITS-1:0]   now;
  logic                   immediate;
  logic                   names_ok;

  modport source (output valid, opcode, peer_slot, now, immediate, names_ok, input ready);
  modport sink   (input valid, opcode, peer_slot, now, immediate, names_ok, output ready);
endinterface

interface prbt_res_if #(
  parameter int TIME_BITS = prbt_pkg::TIME_BITS_DEF
);
  import prbt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 tracked;
  logic                 is_quarantined;
  logic                 in_flight;
  logic [ATT_W-1:0]     attempt_count;
  logic [TIME_BITS-1:0] retry_time;
  logic                 ready_res;
  logic [TOTAL_W-1:0]   tracked_total;
  logic [TOTAL_W-1:0]   quarantined_total;

  modport source (output valid, tracked, is_quarantined, in_flight, attempt_count, retry_time,
                  ready_res, tracked_total, quarantined_total, input ready);
  modport sink   (input valid, tracked, is_quarantined, in_flight, attempt_count, retry_time,
                  ready_res, tracked_total, quarantined_total, output ready);
endinterface

[rtl/peer_retry_backoff_table.sv]
`timescale 1ns / 1ps
// Peer retry backoff table: request register, slot update and result register.
//
// Takes one request per cycle unless the input stalls, and returns one result per request.
// An accepted request is held in the request register and moves on into the result
// register once that is free; the attempt and retry-time memory is read into the request
// register at acceptance. Presence, quarantine and in-flight flags sit in flip-flops
// cleared by reset, so the table is usable straight after reset. While a result waits,
// one further request is taken into the request register and the input then stalls
// until the result is accepted. The user must write registers over the APB port only
// while no request is in progress; the block does not enforce this. pready is always high.
module peer_retry_backoff_table_top #(
  parameter int PEER_SLOTS = prbt_pkg::PEER_SLOTS_DEF,
  parameter int TIME_BITS  = prbt_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  prbt_req_if.sink                        req,
  prbt_res_if.source                      res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prbt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [prbt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [prbt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import prbt_pkg::*;

  localparam int SLOT_W  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CMP_W   = (SLOT_W + 1 > PEER_SLOT_W) ? SLOT_W + 1 : PEER_SLOT_W;
  localparam int COUNT_W = $clog2(PEER_SLOTS + 1);
  localparam int SUM_W   = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // configuration
  logic [BASE_W-1:0]  base_delay;
  logic [DELAY_W-1:0] max_delay;
  logic [ATT_W-1:0]   attempt_limit;
  logic [DELAY_W-1:0] cooldown;
  reg_t               reg_sel;

  // slot flags and memories
  logic [PEER_SLOTS-1:0] present;
  logic [PEER_SLOTS-1:0] quarantined;
  logic [PEER_SLOTS-1:0] pending;
  logic [ATT_W-1:0]      mem_att [PEER_SLOTS];
  logic [TIME_BITS-1:0]  mem_nr  [PEER_SLOTS];
  logic [COUNT_W-1:0]    present_count;
  logic [COUNT_W-1:0]    quarantine_count;

  // request stage
  logic                 s1_valid;
  op_t                  s1_op;
  logic [SLOT_W-1:0]    s1_slot;
  logic                 s1_ok;
  logic [TIME_BITS-1:0] s1_now;
  logic                 s1_imm;
  logic                 s1_names;
  logic [ATT_W-1:0]     rd_att;
  logic [TIME_BITS-1:0] rd_nr;

  // last committed memory write, for forwarding
  logic                 wr_valid;
  logic [SLOT_W-1:0]    wr_slot;
  logic [ATT_W-1:0]     wr_att;
  logic [TIME_BITS-1:0] wr_nr;

  // result register
  logic                 result_valid;
  logic                 result_tracked;
  logic                 result_quar;
  logic                 result_flight;
  logic [ATT_W-1:0]     result_att;
  logic [TIME_BITS-1:0] result_nr;
  logic                 result_ready;
  logic [TOTAL_W-1:0]   result_tracked_total;
  logic [TOTAL_W-1:0]   result_quar_total;

  logic [CMP_W-1:0]     in_ext;
  logic                 in_ok;
  logic [SLOT_W-1:0]    in_slot;
  logic                 accept;
  logic                 commit;

  logic                 fwd;
  logic                 pres;
  logic                 quar;
  logic                 pend;
  logic [ATT_W-1:0]     cur_att;
  logic [TIME_BITS-1:0] cur_nr;
  logic [ATT_W-1:0]     att_inc;
  logic [ATT_W-1:0]     bump_n;
  logic [DELAY_W-1:0]   bo;
  logic                 fail_quar;
  logic [DELAY_W-1:0]   add_d;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] t_sum;
  logic                 sum_ge;
  logic                 old_ge;
  logic                 tv;

  logic                 n_pres;
  logic                 n_quar;
  logic                 n_pend;
  logic [ATT_W-1:0]     n_att;
  logic [TIME_BITS-1:0] n_nr;
  logic                 n_ge;
  logic                 o_tracked;
  logic                 o_ready;
  logic [COUNT_W-1:0]   present_count_next;
  logic [COUNT_W-1:0]   quarantine_count_next;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    unique case (reg_sel)
      REG_BASE_DELAY:    prdata = CFG_DATA_W'(base_delay);
      REG_MAX_DELAY:     prdata = CFG_DATA_W'(max_delay);
      REG_ATTEMPT_LIMIT: prdata = CFG_DATA_W'(attempt_limit);
      REG_COOLDOWN:      prdata = CFG_DATA_W'(cooldown);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay    <= BASE_DELAY_RST;
      max_delay     <= MAX_DELAY_RST;
      attempt_limit <= ATTEMPT_LIMIT_RST;
      cooldown      <= COOLDOWN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_BASE_DELAY:    base_delay    <= pwdata[BASE_W-1:0];
        REG_MAX_DELAY:     max_delay     <= pwdata[DELAY_W-1:0];
        REG_ATTEMPT_LIMIT: attempt_limit <= pwdata[ATT_W-1:0];
        REG_COOLDOWN:      cooldown      <= pwdata[DELAY_W-1:0];
      endcase
    end
  end

  // handshake
  assign commit    = s1_valid && (!result_valid || res.ready);
  assign req.ready = !s1_valid || !result_valid || res.ready;
  assign accept    = req.valid && req.ready;

  assign in_ext  = CMP_W'(req.peer_slot);
  assign in_ok   = in_ext < CMP_W'(PEER_SLOTS);
  assign in_slot = in_ext[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= op_t'(req.opcode);
      s1_slot  <= in_slot;
      s1_ok    <= in_ok;
      s1_now   <= req.now;
      s1_imm   <= req.immediate;
      s1_names <= req.names_ok;
      rd_att   <= mem_att[in_slot];
      rd_nr    <= mem_nr[in_slot];
    end
  end

  // current slot state, with the write committed alongside the read forwarded
  assign fwd     = wr_valid && (wr_slot == s1_slot);
  assign cur_att = fwd ? wr_att : rd_att;
  assign cur_nr  = fwd ? wr_nr : rd_nr;
  assign pres    = present[s1_slot];
  assign quar    = quarantined[s1_slot];
  assign pend    = pending[s1_slot];
  assign tv      = s1_now != '0;

  assign att_inc   = (cur_att == '1) ? cur_att : cur_att + ATT_W'(1);
  assign bump_n    = (s1_op == OP_FAILURE && pend) ? cur_att : att_inc;
  assign bo        = prbt_backoff(base_delay, max_delay, bump_n);
  assign fail_quar = bump_n >= attempt_limit;

  always_comb begin
    priority if (s1_op == OP_CANDIDATE || s1_op == OP_DISCONNECT) begin
      add_d = DELAY_W'(base_delay);
    end else if (s1_op == OP_QUARANTINE || (s1_op == OP_FAILURE && fail_quar)) begin
      add_d = cooldown;
    end else begin
      add_d = bo;
    end
  end

  // saturating time sum
  assign sum    = SUM_W'(s1_now) + SUM_W'(add_d);
  assign t_sum  = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
  assign sum_ge = (add_d == '0) || (s1_now == TIME_MAX);
  assign old_ge = s1_now >= cur_nr;

  always_comb begin
    n_pres = pres;
    n_quar = quar;
    n_pend = pend;
    n_att  = cur_att;
    n_nr   = cur_nr;
    n_ge   = old_ge;
    if (s1_ok) begin
      unique case (s1_op)
        OP_CANDIDATE, OP_DISCONNECT: begin
          if (s1_names && tv) begin
            if (!pres) begin
              n_pres = 1'b1;
              n_quar = 1'b0;
              n_pend = 1'b0;
              n_att  = '0;
              if (s1_op == OP_CANDIDATE && s1_imm) begin
                n_nr = s1_now;
                n_ge = 1'b1;
              end else begin
                n_nr = t_sum;
                n_ge = sum_ge;
              end
            end else if (!quar) begin
              if (s1_op == OP_CANDIDATE) begin
                if (s1_imm && cur_nr > s1_now && cur_att == '0) begin
                  n_nr = s1_now;
                  n_ge = 1'b1;
                end
              end else begin
                n_pend = 1'b0;
                if (cur_nr < t_sum) begin
                  n_nr = t_sum;
                  n_ge = sum_ge;
                end
              end
            end
          end
        end
        OP_ATTEMPT: begin
          if (pres && tv && !quar) begin
            n_att  = bump_n;
            n_nr   = t_sum;
            n_ge   = sum_ge;
            n_pend = 1'b1;
          end
        end
        OP_SUCCESS: begin
          if (pres) begin
            n_pres = 1'b0;
            n_quar = 1'b0;
            n_pend = 1'b0;
          end
        end
        OP_FAILURE: begin
          if (pres && tv) begin
            n_att  = bump_n;
            n_pend = 1'b0;
            n_nr   = t_sum;
            n_ge   = sum_ge;
            if (fail_quar) begin
              n_quar = 1'b1;
            end
          end
        end
        OP_QUARANTINE: begin
          if (s1_names && tv) begin
            if (!pres) begin
              n_pres = 1'b1;
              n_att  = '0;
            end
            n_quar = 1'b1;
            n_pend = 1'b0;
            n_nr   = t_sum;
            n_ge   = sum_ge;
          end
        end
        OP_LIFT: begin
          if (pres) begin
            n_quar = 1'b0;
            n_att  = '0;
            n_pend = 1'b0;
            if (tv) begin
              n_nr = s1_now;
              n_ge = 1'b1;
            end
          end
        end
        OP_QUERY: begin
        end
      endcase
    end
  end

  assign o_tracked = s1_ok && n_pres;
  assign o_ready   = o_tracked && !n_quar && !n_pend && (n_att < attempt_limit) && n_ge;

  assign present_count_next    = present_count + COUNT_W'(s1_ok && n_pres)
                                 - COUNT_W'(s1_ok && pres);
  assign quarantine_count_next = quarantine_count + COUNT_W'(s1_ok && n_quar)
                                 - COUNT_W'(s1_ok && quar);

  // commit slot update
  always_ff @(posedge clk) begin
    if (rst) begin
      present          <= '0;
      quarantined      <= '0;
      pending          <= '0;
      present_count    <= '0;
      quarantine_count <= '0;
      wr_valid         <= 1'b0;
    end else if (commit) begin
      present_count    <= present_count_next;
      quarantine_count <= quarantine_count_next;
      if (s1_ok) begin
        present[s1_slot]     <= n_pres;
        quarantined[s1_slot] <= n_quar;
        pending[s1_slot]     <= n_pend;
        wr_valid             <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && s1_ok) begin
      mem_att[s1_slot] <= n_att;
      mem_nr[s1_slot]  <= n_nr;
      wr_slot          <= s1_slot;
      wr_att           <= n_att;
      wr_nr            <= n_nr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (res.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result_tracked       <= o_tracked;
      result_quar          <= o_tracked && n_quar;
      result_flight        <= o_tracked && n_pend;
      result_att           <= o_tracked ? n_att : '0;
      result_nr            <= o_tracked ? n_nr : '0;
      result_ready         <= o_ready;
      result_tracked_total <= TOTAL_W'(present_count_next);
      result_quar_total    <= TOTAL_W'(quarantine_count_next);
    end
  end

  assign res.valid             = result_valid;
  assign res.tracked           = result_tracked;
  assign res.is_quarantined    = result_quar;
  assign res.in_flight         = result_flight;
  assign res.attempt_count     = result_att;
  assign res.retry_time        = result_nr;
  assign res.ready_res         = result_ready;
  assign res.tracked_total     = result_tracked_total;
  assign res.quarantined_total = result_quar_total;

endmodule

[rtl/prbt_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the peer retry backoff table and their bind to the top level.
module prbt_checker #(
  parameter int TIME_BITS = prbt_pkg::TIME_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_tracked,
  input logic                         res_quar,
  input logic                         res_flight,
  input logic [prbt_pkg::ATT_W-1:0]   res_att,
  input logic [TIME_BITS-1:0]         res_nr,
  input logic                         res_rdy,
  input logic [prbt_pkg::TOTAL_W-1:0] res_tracked_total,
  input logic [prbt_pkg::TOTAL_W-1:0] res_quar_total
);
  import prbt_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_nr) && $stable(res_att))
    else $error("result changed while stalled");

  a_free_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_tracked |-> !res_quar && !res_flight && !res_rdy
                                  && res_att == '0 && res_nr == '0)
    else $error("free slot reports slot state");

  a_ready_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_rdy |-> res_tracked && !res_quar && !res_flight)
    else $error("ready reported on a blocked slot");

  a_totals: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_quar_total <= res_tracked_total)
    else $error("more quarantined than tracked");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result shown straight after reset");

endmodule

bind peer_retry_backoff_table_top prbt_checker #(.TIME_BITS(TIME_BITS)) u_prbt_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_tracked      (res.tracked),
  .res_quar         (res.is_quarantined),
  .res_flight       (res.in_flight),
  .res_att          (res.attempt_count),
  .res_nr           (res.retry_time),
  .res_rdy          (res.ready_res),
  .res_tracked_total(res.tracked_total),
  .res_quar_total   (res.quarantined_total)
);

[sim/backoff_table_checker.sv]
`timescale 1ns / 1ps
// Checker for the peer retry backoff table: tracks the slot table and compares every result.
module backoff_table_checker (
  input  logic                            clk,
  input  logic                            rst,
  prbt_req_if                             req,
  prbt_res_if                             res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [prbt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [prbt_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              mismatches,
  output int                              outstanding
);
  import prbt_pkg::*;

  localparam int TW = TIME_BITS_DEF;
  localparam int SLOTS = PEER_SLOTS_DEF;
  localparam bit [63:0] TIME_TOP = (64'd1 << TW) - 64'd1;

  typedef struct packed {
    bit               tracked;
    bit               quarantined;
    bit               in_flight;
    bit [ATT_W-1:0]   attempts;
    bit [TW-1:0]      retry_at;
    bit               retry_ready;
    bit [TOTAL_W-1:0] n_tracked;
    bit [TOTAL_W-1:0] n_quarantined;
  } peer_view_t;

  bit [BASE_W-1:0]  base_delay_q;
  bit [DELAY_W-1:0] max_delay_q;
  bit [ATT_W-1:0]   attempt_limit_q;
  bit [DELAY_W-1:0] cooldown_q;

  bit             slot_used  [SLOTS];
  bit [ATT_W-1:0] slot_tries [SLOTS];
  bit [TW-1:0]    slot_due   [SLOTS];
  bit             slot_held  [SLOTS];
  bit             slot_busy  [SLOTS];
  int             used_total;
  int             held_total;

  peer_view_t view_q [$];

  function automatic void clear_table();
    base_delay_q    = BASE_DELAY_RST;
    max_delay_q     = MAX_DELAY_RST;
    attempt_limit_q = ATTEMPT_LIMIT_RST;
    cooldown_q      = COOLDOWN_RST;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i]  = 1'b0;
      slot_tries[i] = '0;
      slot_due[i]   = '0;
      slot_held[i]  = 1'b0;
      slot_busy[i]  = 1'b0;
    end
    used_total = 0;
    held_total = 0;
  endfunction

  function automatic bit [TW-1:0] sat_add(bit [63:0] t, bit [63:0] d);
    bit [63:0] s;
    s = t + d;
    return (s > TIME_TOP) ? TIME_TOP[TW-1:0] : s[TW-1:0];
  endfunction

  // double the base once per attempt, stop at the cap once reached
  function automatic bit [63:0] backoff_after(int n);
    bit [63:0] d;
    bit        capped;
    d = 64'(base_delay_q);
    capped = 1'b0;
    for (int i = 0; i < n && !capped; i++) begin
      d = d << 1;
      if (d >= 64'(max_delay_q)) begin
        d = 64'(max_delay_q);
        capped = 1'b1;
      end
    end
    return d;
  endfunction

  function automatic void mark_held(int s, bit q);
    if (q && !slot_held[s]) held_total++;
    if (!q && slot_held[s]) held_total--;
    slot_held[s] = q;
  endfunction

  function automatic void open_slot(int s, bit [TW-1:0] due);
    slot_used[s]  = 1'b1;
    used_total++;
    slot_tries[s] = '0;
    slot_due[s]   = due;
    slot_held[s]  = 1'b0;
    slot_busy[s]  = 1'b0;
  endfunction

  function automatic void count_try(int s);
    if (slot_tries[s] != '1) slot_tries[s] = slot_tries[s] + 1'b1;
  endfunction

  function automatic peer_view_t apply_event(op_t op, int s, bit [TW-1:0] now, bit imm,
                                             bit names);
    peer_view_t  v;
    bit          timed;
    bit          pres;
    bit [TW-1:0] floor_due;
    timed = (now != '0);
    pres  = slot_used[s];
    case (op)
      OP_CANDIDATE, OP_DISCONNECT: begin
        if (names && timed) begin
          if (!pres) begin
            open_slot(s, (op == OP_CANDIDATE && imm) ? now : sat_add(now, base_delay_q));
          end else if (!slot_held[s]) begin
            if (op == OP_CANDIDATE) begin
              if (imm && slot_due[s] > now && slot_tries[s] == '0) slot_due[s] = now;
            end else begin
              floor_due = sat_add(now, base_delay_q);
              slot_busy[s] = 1'b0;
              if (slot_due[s] < floor_due) slot_due[s] = floor_due;
            end
          end
        end
      end
      OP_ATTEMPT: begin
        if (pres && timed && !slot_held[s]) begin
          count_try(s);
          slot_due[s]  = sat_add(now, backoff_after(slot_tries[s]));
          slot_busy[s] = 1'b1;
        end
      end
      OP_SUCCESS: begin
        if (pres) begin
          mark_held(s, 1'b0);
          slot_used[s] = 1'b0;
          slot_busy[s] = 1'b0;
          used_total--;
        end
      end
      OP_FAILURE: begin
        if (pres && timed) begin
          if (!slot_busy[s]) count_try(s);
          slot_busy[s] = 1'b0;
          if (slot_tries[s] >= attempt_limit_q) begin
            mark_held(s, 1'b1);
            slot_due[s] = sat_add(now, cooldown_q);
          end else begin
            slot_due[s] = sat_add(now, backoff_after(slot_tries[s]));
          end
        end
      end
      OP_QUARANTINE: begin
        if (names && timed) begin
          if (!pres) open_slot(s, '0);
          mark_held(s, 1'b1);
          slot_busy[s] = 1'b0;
          slot_due[s]  = sat_add(now, cooldown_q);
        end
      end
      OP_LIFT: begin
        if (pres) begin
          mark_held(s, 1'b0);
          slot_tries[s] = '0;
          slot_busy[s]  = 1'b0;
          if (timed) slot_due[s] = now;
        end
      end
      default: begin
      end
    endcase
    v = '0;
    if (slot_used[s]) begin
      v.tracked     = 1'b1;
      v.quarantined = slot_held[s];
      v.in_flight   = slot_busy[s];
      v.attempts    = slot_tries[s];
      v.retry_at    = slot_due[s];
      v.retry_ready = !slot_held[s] && !slot_busy[s] && slot_tries[s] < attempt_limit_q &&
                      now >= slot_due[s];
    end
    v.n_tracked     = TOTAL_W'(used_total);
    v.n_quarantined = TOTAL_W'(held_total);
    return v;
  endfunction

  task automatic check_field(string name, bit [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    peer_view_t want;
    if (rst) begin
      clear_table();
      view_q.delete();
      outstanding = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_t'(paddr[CFG_ADDR_W-1:2]))
          REG_BASE_DELAY:    base_delay_q    = pwdata[BASE_W-1:0];
          REG_MAX_DELAY:     max_delay_q     = pwdata[DELAY_W-1:0];
          REG_ATTEMPT_LIMIT: attempt_limit_q = pwdata[ATT_W-1:0];
          REG_COOLDOWN:      cooldown_q      = pwdata[DELAY_W-1:0];
        endcase
      end
      if (res.valid && res.ready) begin
        if (view_q.size() == 0) begin
          $error("result arrived with no request waiting");
          mismatches++;
        end else begin
          want = view_q.pop_front();
          check_field("tracked", want.tracked, res.tracked);
          check_field("is_quarantined", want.quarantined, res.is_quarantined);
          check_field("in_flight", want.in_flight, res.in_flight);
          check_field("attempt_count", want.attempts, res.attempt_count);
          check_field("retry_time", want.retry_at, res.retry_time);
          check_field("ready_res", want.retry_ready, res.ready_res);
          check_field("tracked_total", want.n_tracked, res.tracked_total);
          check_field("quarantined_total", want.n_quarantined, res.quarantined_total);
        end
      end
      if (req.valid && req.ready) begin
        want = apply_event(op_t'(req.opcode), int'(req.peer_slot), req.now,
                           req.immediate, req.names_ok);
        view_q.insert(view_q.size(), want);
      end
      outstanding = view_q.size();
    end
  end

endmodule

[sim/peer_retry_backoff_table_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the peer retry backoff table: stimulus, register phases and verdict.
module peer_retry_backoff_table_top_tb;
  import prbt_pkg::*;

  localparam int TW = TIME_BITS_DEF;
  localparam bit [TW-1:0] TIME_END = '1;
  localparam int BATCH = 260;
  localparam int HOLD_LEN = 300;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;

  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  bit          hold_taken;
  int          hold_left;
  int          requests_sent;
  bit [TW-1:0] wall;

  prbt_req_if req_ch ();
  prbt_res_if res_ch ();

  peer_retry_backoff_table_top dut (
    .clk, .rst, .req(req_ch), .res(res_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  backoff_table_checker chk (
    .clk, .rst, .req(req_ch), .res(res_ch),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .outstanding
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // hold the result side off when asked, else stall at random
  initial begin
    res_ch.ready <= 1'b0;
    hold_taken    = 1'b0;
    hold_left     = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic bit [TW-1:0] tick();
    wall = wall + TW'($urandom_range(0, 60));
    return wall;
  endfunction

  function automatic bit [TW-1:0] any_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return TW'({$urandom, $urandom});
    if (r < 13) return TIME_END - TW'($urandom_range(0, 500));
    if (r < 15) return TW'($urandom_range(1, 4));
    return tick();
  endfunction

  function automatic bit [PEER_SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 3) != 0) return PEER_SLOT_W'($urandom_range(0, 11));
    return PEER_SLOT_W'($urandom_range(0, 63));
  endfunction

  task automatic send_event(op_t op, bit [PEER_SLOT_W-1:0] slot, bit [TW-1:0] at, bit imm,
                            bit names);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= op;
    req_ch.peer_slot <= slot;
    req_ch.now       <= at;
    req_ch.immediate <= imm;
    req_ch.names_ok  <= names;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    requests_sent++;
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(reg_t r, logic [CFG_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic configure(int base, int cap, int tries, int cool);
    write_reg(REG_BASE_DELAY, CFG_DATA_W'(base));
    write_reg(REG_MAX_DELAY, CFG_DATA_W'(cap));
    write_reg(REG_ATTEMPT_LIMIT, CFG_DATA_W'(tries));
    write_reg(REG_COOLDOWN, CFG_DATA_W'(cool));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic directed_events();
    send_event(OP_QUERY, 6'd0, '0, 1'b0, 1'b1);
    send_event(OP_CANDIDATE, 6'd0, 48'd100, 1'b0, 1'b0);
    send_event(OP_CANDIDATE, 6'd0, '0, 1'b0, 1'b1);
    send_event(OP_CANDIDATE, 6'd0, 48'd100, 1'b0, 1'b1);
    send_event(OP_CANDIDATE, 6'd0, 48'd101, 1'b1, 1'b1);
    send_event(OP_ATTEMPT, 6'd0, 48'd110, 1'b0, 1'b0);
    send_event(OP_FAILURE, 6'd0, 48'd115, 1'b0, 1'b0);
    send_event(OP_FAILURE, 6'd0, 48'd130, 1'b0, 1'b0);
    send_event(OP_DISCONNECT, 6'd0, 48'd131, 1'b0, 1'b1);
    send_event(OP_DISCONNECT, 6'd63, TIME_END, 1'b0, 1'b1);
    send_event(OP_CANDIDATE, 6'd63, TIME_END, 1'b1, 1'b1);
    send_event(OP_QUARANTINE, 6'd5, 48'd200, 1'b0, 1'b1);
    send_event(OP_ATTEMPT, 6'd5, 48'd210, 1'b0, 1'b1);
    send_event(OP_FAILURE, 6'd5, 48'd300, 1'b0, 1'b1);
    send_event(OP_LIFT, 6'd5, '0, 1'b0, 1'b0);
    send_event(OP_LIFT, 6'd63, 48'd400, 1'b0, 1'b0);
    send_event(OP_SUCCESS, 6'd63, '0, 1'b0, 1'b0);
    send_event(OP_SUCCESS, 6'd63, 48'd410, 1'b0, 1'b1);
    send_event(OP_FAILURE, 6'd7, 48'd420, 1'b0, 1'b1);
    send_event(OP_QUARANTINE, 6'd9, 48'd430, 1'b0, 1'b0);
    send_event(OP_LIFT, 6'd7, 48'd440, 1'b0, 1'b1);
    send_event(OP_QUERY, 6'd0, '0, 1'b1, 1'b0);
    send_event(OP_CANDIDATE, 6'd1, 48'd1, 1'b1, 1'b1);
    send_event(OP_QUARANTINE, 6'd1, TIME_END, 1'b0, 1'b1);
    send_event(OP_QUERY, 6'd1, 48'd500, 1'b0, 1'b1);
  endtask

  // connect, then rounds of attempt and outcome on one peer
  task automatic peer_session();
    bit [PEER_SLOT_W-1:0] s;
    int                   rounds;
    bit                   closed;
    s      = pick_slot();
    rounds = $urandom_range(1, 10);
    closed = 1'b0;
    send_event(($urandom_range(0, 3) == 0) ? OP_DISCONNECT : OP_CANDIDATE, s, tick(),
               1'($urandom_range(0, 1)), 1'b1);
    for (int i = 0; i < rounds && !closed; i++) begin
      if ($urandom_range(0, 4) != 0) begin
        send_event(OP_ATTEMPT, s, tick(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_event(OP_FAILURE, s, tick(), 1'b0, 1'($urandom_range(0, 1)));
        6: send_event(OP_DISCONNECT, s, tick(), 1'b0, 1'b1);
        7: send_event(OP_QUERY, s, tick(), 1'b0, 1'b1);
        default: begin
          send_event(OP_SUCCESS, s, tick(), 1'b0, 1'($urandom_range(0, 1)));
          closed = 1'b1;
        end
      endcase
    end
    if (!closed && $urandom_range(0, 2) == 0) begin
      send_event(OP_LIFT, s, tick(), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_events(int count);
    int start;
    start = requests_sent;
    while (requests_sent - start < count) begin
      if ($urandom_range(0, 9) < 7) begin
        peer_session();
      end else begin
        send_event(op_t'($urandom_range(0, 7)), pick_slot(), any_time(),
                   1'($urandom_range(0, 1)), ($urandom_range(0, 9) != 0));
      end
    end
  endtask

  // drive one peer past the attempt counter's top
  task automatic attempt_flood();
    send_event(OP_SUCCESS, 6'd40, tick(), 1'b0, 1'b1);
    send_event(OP_CANDIDATE, 6'd40, tick(), 1'b1, 1'b1);
    repeat (260) send_event(OP_ATTEMPT, 6'd40, tick(), 1'b0, 1'b1);
    send_event(OP_FAILURE, 6'd40, tick(), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_QUERY;
    req_ch.peer_slot  <= '0;
    req_ch.now        <= '0;
    req_ch.immediate  <= 1'b0;
    req_ch.names_ok   <= 1'b0;
    hold_req          = 1'b0;
    requests_sent     = 0;
    wall              = 48'd1000;
    send_idle_pct     = 31;
    recv_idle_pct     = 69;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_events();
    random_events(BATCH);
    settle();

    configure(1, 24'hFFFFFF, 255, 0);
    attempt_flood();
    random_events(BATCH);
    settle();

    send_idle_pct = 69;
    recv_idle_pct = 31;
    configure(65535, 1, 1, 24'hFFFFFF);
    random_events(BATCH);
    settle();

    configure($urandom_range(1, 50), $urandom_range(1, 2000), $urandom_range(2, 12),
              $urandom_range(0, 5000));
    random_events(BATCH);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(2, 40, 4, 100);
    hold_req = 1'b1;
    random_events(BATCH);
    settle();

    configure($urandom_range(1, 50), $urandom_range(1, 2000), $urandom_range(2, 12),
              $urandom_range(0, 5000));
    random_events(BATCH);
    settle();

    repeat (8) @(posedge clk);
    $display("Sent %0d requests over six register settings, both idling mixes,", requests_sent);
    $display("no idling, a 300-cycle result hold-off and an attempt counter flood.");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/prbt_pkg.sv
rtl/prbt_if.sv
rtl/peer_retry_backoff_table.sv
rtl/prbt_checker.sv
sim/backoff_table_checker.sv
sim/peer_retry_backoff_table_top_tb.sv
